### hw/rtl/bba_pkg.sv
package bba_pkg;

    localparam int NUM_CLASSES       = 12;
    localparam int MIN_BLOCK_SHIFT   = 6;
    localparam int PAGE_SHIFT        = 12;
    localparam int POOL_COUNT        = 4;
    localparam int UNUSED_POOL_INDEX = 0;

    // Heap addresses are fixed at 12 bits of minimum-block units.
    localparam int ADDR_W      = 12;
    localparam int ADDR_UNITS  = 4096;
    localparam int WORD_BITS   = 64;
    localparam int WIDX_W      = 6;
    localparam int BIT_W       = 6;
    localparam logic [ADDR_W-1:0] ADDR_MASK = 12'hFFF;

    localparam int CLASS_IDX_W = $clog2(NUM_CLASSES);
    localparam int CLASS_W     = $clog2(NUM_CLASSES + 1);
    localparam int MEM_DEPTH   = NUM_CLASSES * WORD_BITS;
    localparam int MEM_AW      = CLASS_IDX_W + WIDX_W;
    localparam int PAGE_D      = (PAGE_SHIFT > MIN_BLOCK_SHIFT) ?
                                 (PAGE_SHIFT - MIN_BLOCK_SHIFT) : 0;
    localparam bit POOL_OK     = (UNUSED_POOL_INDEX < POOL_COUNT) &&
                                 (UNUSED_POOL_INDEX < 4);

    typedef enum logic [1:0] {
        FUNC_ALLOC   = 2'd0,
        FUNC_RELEASE = 2'd1,
        FUNC_REBUILD = 2'd2,
        FUNC_NONE    = 2'd3
    } t_func;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SEED,
        ST_A_RD,
        ST_A_CHK,
        ST_SPLIT,
        ST_R_SET_RD,
        ST_R_SET_WR,
        ST_R_SC_RD,
        ST_R_SC_LD,
        ST_R_SC_BIT,
        ST_M1_RD,
        ST_M1_WR,
        ST_M2_RD,
        ST_M2_WR,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                 we;
        logic [MEM_AW-1:0]    waddr;
        logic [WORD_BITS-1:0] wdata;
        logic [MEM_AW-1:0]    raddr;
    } t_mem_req;

    function automatic logic [MEM_AW-1:0] mem_addr(input logic [CLASS_W-1:0] c,
                                                   input logic [WIDX_W-1:0] w);
        mem_addr = {c[CLASS_IDX_W-1:0], w};
    endfunction

    // Block size of a class in units, reduced modulo the heap size.
    function automatic logic [ADDR_W-1:0] unit_offset(input logic [CLASS_W-1:0] c);
        unit_offset = (int'(c) < ADDR_W) ? (12'd1 << c) : 12'd0;
    endfunction

    // Merge alignment of a class: its block size, capped at one page.
    function automatic logic [ADDR_W-1:0] align_mask(input logic [CLASS_W-1:0] c);
        int sh;
        sh = (int'(c) < PAGE_D) ? int'(c) : PAGE_D;
        if (sh >= ADDR_W) begin
            align_mask = ADDR_MASK;
        end else begin
            align_mask = (12'd1 << sh) - 12'd1;
        end
    endfunction

    function automatic logic [WORD_BITS-1:0] bit_of(input logic [BIT_W-1:0] b);
        bit_of = 64'd1 << b;
    endfunction

endpackage

### hw/rtl/buddy_block_allocator.sv
// Binary buddy allocator over a 4096-unit heap. Each size class keeps its free blocks as a
// bitmap in one on-chip memory of 64-bit words (one row of 64 words per class). A request
// is taken only while the block is idle and produces exactly one response. The work is done
// by a sequencer around one lowest-set-bit finder and the one bitmap memory, so the
// latency depends on the data: an allocate reads and checks each bitmap word scanned, plus
// one release pass per split level; a release costs a read-modify-write plus a scan of
// the class that reads and loads each word and walks every free block seen in it, and every
// merge level clears the pair with a read-modify-write of each buddy and then repeats the
// whole pass one class up; a rebuild first clears the whole map, all NUM_CLASSES*64 words
// (768), and then seeds one class per cycle. After reset the same clearing pass runs
// before the first request is accepted; configuration writes to heap_units are taken at
// any time.
module buddy_block_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: heap_units.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [11:0] i_cfg_data,
    // Requests. tdata: size_class[3:0], block_addr[15:4], allowed_pools[19:16], zero fill.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,
    // tuser: func[1:0].
    input  logic [1:0]  s_axis_tuser,
    // Responses. tdata: granted_addr[11:0], zero fill.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,
    // tuser: ok[0].
    output logic [0:0]  m_axis_tuser
);
    import bba_pkg::*;

    t_state               r_state, n_state;
    logic [MEM_AW-1:0]    r_clr, n_clr;
    logic                 r_rebuild, n_rebuild;
    logic                 r_is_alloc, n_is_alloc;
    logic [CLASS_W-1:0]   r_cls, n_cls;
    logic [CLASS_W-1:0]   r_c, n_c;
    logic [CLASS_W-1:0]   r_k, n_k;
    logic [CLASS_W-1:0]   r_j, n_j;
    logic [WIDX_W-1:0]    r_widx, n_widx;
    logic [ADDR_W-1:0]    r_a, n_a;
    logic [ADDR_W-1:0]    r_prev, n_prev;
    logic                 r_prev_v, n_prev_v;
    logic [ADDR_W-1:0]    r_cur, n_cur;
    logic [WORD_BITS-1:0] r_word, n_word;
    logic [ADDR_W-1:0]    r_pos, n_pos;
    logic [ADDR_W-1:0]    r_heap;
    logic                 r_ok, n_ok;
    logic [ADDR_W-1:0]    r_gaddr, n_gaddr;

    t_mem_req             mem_req;
    logic [WORD_BITS-1:0] mem_rdata;
    logic [WORD_BITS-1:0] scan_word;
    logic                 scan_found;
    logic [BIT_W-1:0]     scan_idx;

    t_func                req_func;
    logic [3:0]           req_cls;
    logic [ADDR_W-1:0]    req_addr;
    logic [3:0]           req_pools;
    logic                 req_cls_ok;
    logic                 req_pool_ok;
    logic [ADDR_W-1:0]    found_addr;
    logic                 last_class;
    logic                 pair_merge;

    bba_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    // The one bit finder serves both the allocation search and the merge scan.
    assign scan_word = (r_state == ST_A_CHK) ? mem_rdata : r_word;

    bba_scan u_scan (
        .i_word  (scan_word),
        .o_found (scan_found),
        .o_idx   (scan_idx)
    );

    assign req_func    = t_func'(s_axis_tuser);
    assign req_cls     = s_axis_tdata[3:0];
    assign req_addr    = s_axis_tdata[15:4];
    assign req_pools   = s_axis_tdata[19:16];
    assign req_cls_ok  = int'(req_cls) < NUM_CLASSES;
    assign req_pool_ok = POOL_OK && (((req_pools >> UNUSED_POOL_INDEX) & 4'd1) != 4'd0);

    assign found_addr  = {r_widx, scan_idx};
    assign last_class  = (int'(r_c) + 1) >= NUM_CLASSES;

    // A merge needs the previous free block aligned for the next class and its buddy
    // to be the very next free block of this class.
    assign pair_merge  = r_prev_v &&
                         ((r_prev & align_mask(CLASS_W'(r_c + 1'b1))) == '0) &&
                         (({1'b0, r_prev} + {1'b0, unit_offset(r_c)}) ==
                          {1'b0, found_addr});

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_DONE);
    assign m_axis_tdata  = {4'd0, r_gaddr};
    assign m_axis_tuser  = r_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr     <= '0;
            r_rebuild <= 1'b0;
            r_heap    <= '0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_rebuild <= n_rebuild;
            if (i_cfg_valid && o_cfg_ready) begin
                r_heap <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_alloc <= n_is_alloc;
        r_cls      <= n_cls;
        r_c        <= n_c;
        r_k        <= n_k;
        r_j        <= n_j;
        r_widx     <= n_widx;
        r_a        <= n_a;
        r_prev     <= n_prev;
        r_prev_v   <= n_prev_v;
        r_cur      <= n_cur;
        r_word     <= n_word;
        r_pos      <= n_pos;
        r_ok       <= n_ok;
        r_gaddr    <= n_gaddr;
    end

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_rebuild  = r_rebuild;
        n_is_alloc = r_is_alloc;
        n_cls      = r_cls;
        n_c        = r_c;
        n_k        = r_k;
        n_j        = r_j;
        n_widx     = r_widx;
        n_a        = r_a;
        n_prev     = r_prev;
        n_prev_v   = r_prev_v;
        n_cur      = r_cur;
        n_word     = r_word;
        n_pos      = r_pos;
        n_ok       = r_ok;
        n_gaddr    = r_gaddr;
        mem_req    = '0;

        case (r_state)
            ST_CLEAR: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = r_clr;
                if (int'(r_clr) == MEM_DEPTH - 1) begin
                    n_clr = '0;
                    if (r_rebuild) begin
                        n_rebuild = 1'b0;
                        n_k       = CLASS_W'(NUM_CLASSES - 1);
                        n_pos     = '0;
                        n_state   = ST_SEED;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_clr = MEM_AW'(r_clr + 1'b1);
                end
            end

            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_ok    = 1'b0;
                    n_gaddr = '0;
                    n_state = ST_DONE;
                    case (req_func)
                        FUNC_ALLOC: begin
                            if (req_cls_ok && req_pool_ok) begin
                                n_is_alloc = 1'b1;
                                n_cls      = CLASS_W'(req_cls);
                                n_k        = CLASS_W'(req_cls);
                                n_widx     = '0;
                                n_state    = ST_A_RD;
                            end
                        end
                        FUNC_RELEASE: begin
                            if (req_cls_ok) begin
                                n_is_alloc = 1'b0;
                                n_c        = CLASS_W'(req_cls);
                                n_a        = req_addr;
                                n_state    = ST_R_SET_RD;
                            end
                        end
                        FUNC_REBUILD: begin
                            n_rebuild = 1'b1;
                            n_clr     = '0;
                            n_state   = ST_CLEAR;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // The map is all zero here, so each seed block is written without a read.
            ST_SEED: begin
                if ((int'(r_k) < ADDR_W) && (((r_heap >> r_k) & 12'd1) != 12'd0)) begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = mem_addr(r_k, r_pos[11:6]);
                    mem_req.wdata = bit_of(r_pos[5:0]);
                    n_pos         = r_pos + unit_offset(r_k);
                end
                if (r_k == '0) begin
                    n_ok    = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    n_k = CLASS_W'(r_k - 1'b1);
                end
            end

            ST_A_RD: begin
                mem_req.raddr = mem_addr(r_k, r_widx);
                n_state       = ST_A_CHK;
            end

            ST_A_CHK: begin
                if (scan_found) begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = mem_addr(r_k, r_widx);
                    mem_req.wdata = mem_rdata & ~bit_of(scan_idx);
                    n_gaddr       = found_addr;
                    n_j           = r_k;
                    n_state       = ST_SPLIT;
                end else if (r_widx != '1) begin
                    n_widx  = WIDX_W'(r_widx + 1'b1);
                    n_state = ST_A_RD;
                end else if ((int'(r_k) + 1) < NUM_CLASSES) begin
                    n_k     = CLASS_W'(r_k + 1'b1);
                    n_widx  = '0;
                    n_state = ST_A_RD;
                end else begin
                    n_state = ST_DONE;
                end
            end

            // Free the upper half at each level between the found class and the request.
            ST_SPLIT: begin
                if (r_j > r_cls) begin
                    n_j     = CLASS_W'(r_j - 1'b1);
                    n_c     = CLASS_W'(r_j - 1'b1);
                    n_a     = r_gaddr + unit_offset(CLASS_W'(r_j - 1'b1));
                    n_state = ST_R_SET_RD;
                end else begin
                    n_ok    = 1'b1;
                    n_state = ST_DONE;
                end
            end

            ST_R_SET_RD: begin
                mem_req.raddr = mem_addr(r_c, r_a[11:6]);
                n_state       = ST_R_SET_WR;
            end

            ST_R_SET_WR: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = mem_addr(r_c, r_a[11:6]);
                mem_req.wdata = mem_rdata | bit_of(r_a[5:0]);
                if (last_class) begin
                    n_state = r_is_alloc ? ST_SPLIT : ST_DONE;
                    n_ok    = r_is_alloc ? r_ok : 1'b1;
                end else begin
                    n_widx   = '0;
                    n_prev_v = 1'b0;
                    n_state  = ST_R_SC_RD;
                end
            end

            ST_R_SC_RD: begin
                mem_req.raddr = mem_addr(r_c, r_widx);
                n_state       = ST_R_SC_LD;
            end

            ST_R_SC_LD: begin
                n_word  = mem_rdata;
                n_state = ST_R_SC_BIT;
            end

            // Walk the free blocks of the class in address order, one per cycle within each loaded word.
            ST_R_SC_BIT: begin
                if (!scan_found) begin
                    if (r_widx == '1) begin
                        n_state = r_is_alloc ? ST_SPLIT : ST_DONE;
                        n_ok    = r_is_alloc ? r_ok : 1'b1;
                    end else begin
                        n_widx  = WIDX_W'(r_widx + 1'b1);
                        n_state = ST_R_SC_RD;
                    end
                end else if (pair_merge) begin
                    n_cur   = found_addr;
                    n_state = ST_M1_RD;
                end else begin
                    n_prev   = found_addr;
                    n_prev_v = 1'b1;
                    n_word   = r_word & ~bit_of(scan_idx);
                end
            end

            ST_M1_RD: begin
                mem_req.raddr = mem_addr(r_c, r_prev[11:6]);
                n_state       = ST_M1_WR;
            end

            ST_M1_WR: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = mem_addr(r_c, r_prev[11:6]);
                mem_req.wdata = mem_rdata & ~bit_of(r_prev[5:0]);
                n_state       = ST_M2_RD;
            end

            ST_M2_RD: begin
                mem_req.raddr = mem_addr(r_c, r_cur[11:6]);
                n_state       = ST_M2_WR;
            end

            // The merged block is released one class up.
            ST_M2_WR: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = mem_addr(r_c, r_cur[11:6]);
                mem_req.wdata = mem_rdata & ~bit_of(r_cur[5:0]);
                n_c           = CLASS_W'(r_c + 1'b1);
                n_a           = r_prev;
                n_state       = ST_R_SET_RD;
            end

            ST_DONE: begin
                if (m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // A new request is only taken once the previous response has gone.
    a_ready_no_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("request accepted while a response is pending");

    // A failed response carries a zero address.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 16'd0))
        else $error("failed response carries an address");

    // An accepted request takes the block out of the idle state.
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("block stayed ready after a request");

    // Bitmap writes stay inside the class rows.
    a_mem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_req.we |-> (int'(mem_req.waddr) < MEM_DEPTH))
        else $error("bitmap write outside the map");

endmodule

### hw/rtl/bba_mem.sv
module bba_mem (
    input  logic                           i_clk,
    input  bba_pkg::t_mem_req              i_req,
    output logic [bba_pkg::WORD_BITS-1:0]  o_rdata
);
    import bba_pkg::*;

    logic [WORD_BITS-1:0] r_mem [MEM_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.raddr];
    end

endmodule

### hw/rtl/bba_scan.sv
module bba_scan (
    input  logic [bba_pkg::WORD_BITS-1:0] i_word,
    output logic                          o_found,
    output logic [bba_pkg::BIT_W-1:0]     o_idx
);
    import bba_pkg::*;

    // Lowest set bit of one bitmap word.
    always_comb begin
        o_found = |i_word;
        o_idx   = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (i_word[i]) begin
                o_idx = BIT_W'(i);
            end
        end
    end

endmodule

### dv/buddy_block_allocator_tb.sv
module buddy_block_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bba_pkg::*;

    // Expected response of one request: the ok flag and the granted offset.
    typedef struct {
        logic              ok;
        logic [ADDR_W-1:0] addr;
    } t_grant;

    // Scoreboard that keeps its own copy of the free bitmaps and heap size. Every
    // accepted request is folded into that copy and the response it must cause is
    // queued; responses from the block are checked in order against that queue.
    class heap_scoreboard;
        bit [ADDR_UNITS-1:0] free_bits [NUM_CLASSES];
        logic [ADDR_W-1:0]   heap_size;
        t_grant              grants_due[$];
        int                  fail_count;

        function new();
            foreach (free_bits[c]) free_bits[c] = '0;
            heap_size  = '0;
            fail_count = 0;
        endfunction

        // Lowest free address at or above from in class c, ADDR_UNITS if none.
        function int lowest_free(int c, int from);
            for (int a = from; a < ADDR_UNITS; a++) begin
                if (free_bits[c][a]) return a;
            end
            return ADDR_UNITS;
        endfunction

        // Merge alignment: block size, capped at one page.
        function int merge_align(int c);
            int pg;
            pg = 1 << PAGE_D;
            return ((1 << c) >= pg) ? pg : (1 << c);
        endfunction

        // Insert a block, then merge the lowest aligned adjacent pair upward.
        function void free_block(int c, int a);
            int  cur;
            int  nxt;
            bit  merged;
            a = a & ADDR_MASK;
            forever begin
                merged = 0;
                free_bits[c][a] = 1'b1;
                if (c + 1 >= NUM_CLASSES) return;
                cur = lowest_free(c, 0);
                while (cur < ADDR_UNITS) begin
                    nxt = lowest_free(c, cur + 1);
                    if (nxt >= ADDR_UNITS) break;
                    if ((cur % merge_align(c + 1)) == 0 && cur + (1 << c) == nxt) begin
                        free_bits[c][cur] = 1'b0;
                        free_bits[c][nxt] = 1'b0;
                        a = cur;
                        c++;
                        merged = 1;
                        break;
                    end
                    cur = nxt;
                end
                if (!merged) return;
            end
        endfunction

        function bit take_block(int c, output int a);
            int k;
            k = c;
            while (k < NUM_CLASSES && lowest_free(k, 0) >= ADDR_UNITS) k++;
            if (k >= NUM_CLASSES) return 0;
            a = lowest_free(k, 0);
            free_bits[k][a] = 1'b0;
            // Split down, freeing each upper half (which wraps at the heap end).
            for (int j = k; j > c; j--) free_block(j - 1, (a + (1 << (j - 1))) & ADDR_MASK);
            return 1;
        endfunction

        // Note one accepted request and return the response it must produce.
        function t_grant note_request(t_func f, logic [3:0] cls, logic [ADDR_W-1:0] baddr,
                                      logic [3:0] pools);
            t_grant g;
            int     a;
            int     pos;
            g.ok   = 1'b0;
            g.addr = '0;
            case (f)
                FUNC_ALLOC: begin
                    if (cls < NUM_CLASSES && POOL_OK && pools[UNUSED_POOL_INDEX]) begin
                        if (take_block(cls, a)) begin
                            g.ok   = 1'b1;
                            g.addr = a[ADDR_W-1:0];
                        end
                    end
                end
                FUNC_RELEASE: begin
                    if (cls < NUM_CLASSES) begin
                        free_block(cls, baddr);
                        g.ok = 1'b1;
                    end
                end
                FUNC_REBUILD: begin
                    // Seed from heap_size, largest class first, at a running offset.
                    foreach (free_bits[c]) free_bits[c] = '0;
                    pos = 0;
                    for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
                        if (i < ADDR_W && heap_size[i]) begin
                            free_bits[i][pos & ADDR_MASK] = 1'b1;
                            pos += 1 << i;
                        end
                    end
                    g.ok = 1'b1;
                end
                default: ;
            endcase
            grants_due.push_back(g);
            return g;
        endfunction

        function void check_response(logic ok, logic [ADDR_W-1:0] addr);
            t_grant g;
            if (grants_due.size() == 0) begin
                $display("%0t: response with none outstanding: ok %0d addr %0d",
                         $realtime, ok, addr);
                fail_count++;
                return;
            end
            g = grants_due.pop_front();
            if (ok !== g.ok) begin
                $display("%0t: ok mismatch: expected %0d actual %0d", $realtime, g.ok, ok);
                fail_count++;
            end
            if (addr !== g.addr) begin
                $display("%0t: granted_addr mismatch: expected %0d actual %0d",
                         $realtime, g.addr, addr);
                fail_count++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [11:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    buddy_block_allocator u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    heap_scoreboard heap_sb;

    // Blocks handed out and not yet given back, so releases can return real blocks.
    logic [3:0]        live_class[$];
    logic [ADDR_W-1:0] live_addr[$];

    bit send_gaps;      // sender inserts random idle cycles between requests
    bit recv_gaps;      // receiver inserts random stalls
    int hold_off_req;   // receiver holds off for this many cycles when nonzero

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // The watchdog time is far beyond the slowest correct run, including the
    // clearing passes and the long receiver stalls.
    initial begin
        #1s;
        $display("RESULT: ERROR");
        $finish;
    end

    // Idle length: mostly zero or short, now and then a long gap.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Response side. It stalls at random, and on request holds off for a long
    // stretch so that the block fills up and stops taking requests.
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        forever begin
            if (hold_off_req > 0) begin
                stall        = hold_off_req;
                hold_off_req = 0;
            end else begin
                stall = recv_gaps ? pick_gap() : 0;
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!(m_axis_tvalid && m_axis_tready)) @(posedge i_clk);
            heap_sb.check_response(m_axis_tuser[0], m_axis_tdata[ADDR_W-1:0]);
        end
    end

    // Offer one request and wait for it to be accepted. Valid stays high between
    // back-to-back requests, so within this task it is only lowered when a gap is inserted.
    task automatic send_request(t_func f, logic [3:0] cls, logic [ADDR_W-1:0] baddr,
                                logic [3:0] pools);
        int     gap;
        t_grant g;
        gap = send_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= f;
        s_axis_tdata  <= {4'b0, pools, baddr, cls};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        g = heap_sb.note_request(f, cls, baddr, pools);
        if (f == FUNC_ALLOC && g.ok) begin
            live_class.push_back(cls);
            live_addr.push_back(g.addr);
        end
        if (f == FUNC_REBUILD) begin
            live_class.delete();
            live_addr.delete();
        end
    endtask

    // Wait until every outstanding response has arrived, then let the sequencer
    // settle before anything is written to the configuration.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (heap_sb.grants_due.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_heap_units(logic [11:0] units);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= units;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        heap_sb.heap_size = units;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // One random request. Most traffic is allocation of small classes and return
    // of live blocks, which keeps the heap busy with splits and merges; the rest
    // is noise: releases of arbitrary blocks, bad classes, rebuilds, unknown funcs.
    task automatic random_request();
        int         r;
        int         idx;
        logic [3:0] cls;
        logic [3:0] pools;
        r     = $urandom_range(0, 99);
        pools = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 99) < 85) pools[UNUSED_POOL_INDEX] = 1'b1;
        if (r < 45) begin
            if ($urandom_range(0, 9) < 8) cls = 4'($urandom_range(0, 4));
            else cls = 4'($urandom_range(0, 15));
            send_request(FUNC_ALLOC, cls, 12'($urandom_range(0, 4095)), pools);
        end else if (r < 80 && live_addr.size() > 0) begin
            idx = $urandom_range(0, live_addr.size() - 1);
            send_request(FUNC_RELEASE, live_class[idx], live_addr[idx], pools);
            live_class.delete(idx);
            live_addr.delete(idx);
        end else if (r < 91) begin
            send_request(FUNC_RELEASE, 4'($urandom_range(0, 15)),
                         12'($urandom_range(0, 4095)), pools);
        end else if (r < 96) begin
            send_request(FUNC_REBUILD, 4'($urandom_range(0, 15)),
                         12'($urandom_range(0, 4095)), pools);
        end else begin
            send_request(FUNC_NONE, 4'($urandom_range(0, 15)),
                         12'($urandom_range(0, 4095)), pools);
        end
    endtask

    initial begin
        logic [11:0] heap_plan[6];
        heap_sb       = new();
        send_gaps     = 1'b1;
        recv_gaps     = 1'b1;
        hold_off_req  = 0;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = FUNC_ALLOC;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. The heap is empty after reset, so the first allocation fails.
        send_request(FUNC_ALLOC, 4'd0, 12'd0, 4'hF);
        send_request(FUNC_RELEASE, 4'd12, 12'd5, 4'h0);     // class out of range
        send_request(FUNC_NONE, 4'd3, 12'hFFF, 4'hF);       // unknown func
        drain();
        write_heap_units(12'hFFF);
        send_request(FUNC_REBUILD, 4'd0, 12'd0, 4'h0);
        send_request(FUNC_ALLOC, 4'd0, 12'd0, 4'hE);        // pool mask lacks the used pool
        send_request(FUNC_ALLOC, 4'd11, 12'd0, 4'h1);
        send_request(FUNC_ALLOC, 4'd0, 12'd0, 4'hF);
        send_request(FUNC_ALLOC, 4'd13, 12'd0, 4'hF);       // class out of range
        send_request(FUNC_ALLOC, 4'd15, 12'd0, 4'h1);
        send_request(FUNC_ALLOC, 4'd3, 12'd0, 4'hF);
        send_request(FUNC_RELEASE, 4'd0, 12'hFFF, 4'hF);    // block lies past the heap end
        send_request(FUNC_RELEASE, 4'd11, 12'd0, 4'h0);
        send_request(FUNC_RELEASE, 4'd11, 12'd0, 4'h0);     // double release
        send_request(FUNC_RELEASE, 4'd11, 12'd3000, 4'h0);
        send_request(FUNC_ALLOC, 4'd10, 12'd0, 4'hF);
        send_request(FUNC_ALLOC, 4'd0, 12'd0, 4'hF);
        send_request(FUNC_RELEASE, 4'd5, 12'hAAA, 4'h5);
        send_request(FUNC_RELEASE, 4'd5, 12'h555, 4'hA);
        send_request(FUNC_ALLOC, 4'd11, 12'd0, 4'hF);
        send_request(FUNC_NONE, 4'd11, 12'd0, 4'hF);

        // Random phases, each with its own heap size, extremes included.
        heap_plan[0] = 12'd0;
        heap_plan[1] = 12'hFFF;
        heap_plan[2] = 12'd1;
        heap_plan[3] = 12'($urandom_range(0, 4095));
        heap_plan[4] = 12'd2048;
        heap_plan[5] = 12'($urandom_range(0, 4095));
        for (int ph = 0; ph < 6; ph++) begin
            // The sender pauses here until every expected response has come.
            drain();
            write_heap_units(heap_plan[ph]);
            send_gaps = (ph != 3);
            recv_gaps = (ph != 4);
            send_request(FUNC_REBUILD, 4'd0, 12'd0, 4'h0);
            if (ph == 1) hold_off_req = 400;
            for (int n = 0; n < 138; n++) random_request();
        end

        drain();
        if (heap_sb.fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### buddy_block_allocator.f
hw/rtl/bba_pkg.sv
hw/rtl/bba_mem.sv
hw/rtl/bba_scan.sv
hw/rtl/buddy_block_allocator.sv
dv/buddy_block_allocator_tb.sv
